>>> rtl/core/srt_pkg.sv
// Shared types and constants for the sample ring edge trigger block.
package srt_pkg;

  localparam int SAMPLE_W = 12;
  localparam int IDX_W    = 11;
  localparam int OVF_W    = 32;

  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd2048;

  // tuser codes on the input channel
  localparam logic SRT_OP_STORE  = 1'b0;
  localparam logic SRT_OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    SRT_IDLE,
    SRT_LOAD,
    SRT_SCAN,
    SRT_RESULT
  } srt_state_t;

  // operands handed to the edge compare unit
  typedef struct packed {
    logic [SAMPLE_W-1:0] here;
    logic [SAMPLE_W-1:0] prior;
    logic [SAMPLE_W-1:0] level;
    logic                falling;
  } srt_cmp_req_t;

endpackage

>>> rtl/core/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/srt_edge_cmp.sv
// Edge compare unit: tests one pair of adjacent samples for a level crossing.
module srt_edge_cmp (
  input  srt_pkg::srt_cmp_req_t req,
  output logic                  crossing
);

  logic here_hi;
  logic prior_hi;

  always_comb begin
    here_hi  = (req.here >= req.level);
    prior_hi = (req.prior >= req.level);
    // rising: prior below, here at or above; falling: the reverse
    if (req.falling) begin
      crossing = !here_hi && prior_hi;
    end else begin
      crossing = here_hi && !prior_hi;
    end
  end

endmodule

>>> rtl/core/sample_ring_edge_trigger_unit.sv
// Top level: capture ring with edge trigger search and result register.
//
// Usage
//   Input channel (in_*): one transaction per item. in_tuser selects the
//   kind: store a sample, or search for a trigger edge. A store writes the
//   sample at the next ring position and counts an overflow if flagged; it
//   gives no result. A search gives one result on the output channel
//   (out_*): trigger index, found flag, overflow total.
//   Throughput: a store every cycle while idle. A search holds in_tready
//   low through its load, scan and result states, testing at most
//   RING_DEPTH/2 adjacent pairs. The walk reads one ring entry per cycle
//   through the single RAM read port, and one shared compare unit tests
//   each adjacent pair. The result register is loaded in the result state.
//   Reset: the ring reads as all zero, the write pointer sits at the last
//   entry, the overflow count is zero and the trigger level is 2048. A fill
//   count stands in for clearing, so the block is ready right after reset.
//   Stall: the result register holds while out_tready is low. A search that
//   finishes then waits in its result state; stores are not taken meanwhile.
//   cfg_wr_en writes the trigger level; write it only while idle.
module sample_ring_edge_trigger_unit #(
  parameter int RING_DEPTH   = 2048,
  parameter int SCREEN_WIDTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: trigger level
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, [12] overflow, [13] falling_edge
  input  logic        in_tuser,   // [0] op
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [10:0] trigger_index, [11] found, [43:12] overflow_total
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = srt_pkg::SAMPLE_W;
  localparam logic [AW-1:0] HALF_SCREEN = AW'(SCREEN_WIDTH / 2);
  localparam logic [AW-1:0] LAST_STEP   = AW'(RING_DEPTH / 2 - 1);
  localparam logic [AW:0]   FULL_COUNT  = (AW+1)'(RING_DEPTH);

  // input fields
  logic [SW-1:0] in_sample;
  logic          in_overflow;
  logic          in_falling;
  assign in_sample   = in_tdata[11:0];
  assign in_overflow = in_tdata[12];
  assign in_falling  = in_tdata[13];

  // state
  srt_pkg::srt_state_t state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW:0]     fill_r, fill_nxt;
  logic [31:0]     ovf_cnt_r, ovf_cnt_nxt;
  logic [SW-1:0]   level_r;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [AW-1:0]   step_r, step_nxt;
  logic [SW-1:0]   here_r, here_nxt;
  logic            falling_r, falling_nxt;
  logic            rd_ok_r;
  logic [AW-1:0]   res_pos_r, res_pos_nxt;
  logic            res_hit_r, res_hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [10:0]     out_idx_r, out_idx_nxt;
  logic            out_found_r, out_found_nxt;
  logic [31:0]     out_total_r, out_total_nxt;

  // ring access
  logic            ram_we;
  logic [AW-1:0]   ram_rd_addr;
  logic [SW-1:0]   ram_rd_data;
  logic [SW-1:0]   rd_sample;
  logic            rd_ok;

  logic                  in_fire;
  srt_pkg::srt_cmp_req_t cmp_req;
  logic                  crossing;

  assign in_tready = (state_r == srt_pkg::SRT_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  srt_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_nxt),
    .wr_data (in_sample),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // entries beyond the fill count were never written and read as zero
  assign rd_ok     = fill_r[AW] || ({1'b0, ram_rd_addr} < fill_r);
  assign rd_sample = rd_ok_r ? ram_rd_data : '0;

  assign cmp_req.here    = here_r;
  assign cmp_req.prior   = rd_sample;
  assign cmp_req.level   = level_r;
  assign cmp_req.falling = falling_r;

  srt_edge_cmp u_cmp (
    .req      (cmp_req),
    .crossing (crossing)
  );

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    ovf_cnt_nxt   = ovf_cnt_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    step_nxt      = step_r;
    here_nxt      = here_r;
    falling_nxt   = falling_r;
    res_pos_nxt   = res_pos_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;
    out_total_nxt = out_total_r;
    ram_we        = 1'b0;
    ram_rd_addr   = wp_r - HALF_SCREEN;

    unique case (state_r)
      srt_pkg::SRT_IDLE: begin
        if (in_fire) begin
          if (in_tuser == srt_pkg::SRT_OP_STORE) begin
            // advance pointer, write sample at the new position
            wp_nxt = wp_r + 1'b1;
            ram_we = 1'b1;
            if (!fill_r[AW]) begin
              fill_nxt = fill_r + 1'b1;
            end
            if (in_overflow) begin
              ovf_cnt_nxt = ovf_cnt_r + 32'd1;
            end
          end else begin
            // ring[start] is being read this cycle
            start_nxt   = ram_rd_addr;
            pos_nxt     = ram_rd_addr;
            falling_nxt = in_falling;
            state_nxt   = srt_pkg::SRT_LOAD;
          end
        end
      end
      srt_pkg::SRT_LOAD: begin
        here_nxt    = rd_sample;
        step_nxt    = '0;
        ram_rd_addr = pos_r - 1'b1;
        state_nxt   = srt_pkg::SRT_SCAN;
      end
      srt_pkg::SRT_SCAN: begin
        // rd_sample holds ring[pos - 1]; fetch the next one ahead
        ram_rd_addr = pos_r - 2'd2;
        if (crossing) begin
          res_pos_nxt = pos_r;
          res_hit_nxt = 1'b1;
          state_nxt   = srt_pkg::SRT_RESULT;
        end else if (step_r == LAST_STEP) begin
          res_pos_nxt = start_r;
          res_hit_nxt = 1'b0;
          state_nxt   = srt_pkg::SRT_RESULT;
        end else begin
          here_nxt = rd_sample;
          pos_nxt  = pos_r - 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      srt_pkg::SRT_RESULT: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 11'(res_pos_r);
          out_found_nxt = res_hit_r;
          out_total_nxt = ovf_cnt_r;
          state_nxt     = srt_pkg::SRT_IDLE;
        end
      end
      default: begin
        state_nxt = srt_pkg::SRT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::SRT_IDLE;
      wp_r        <= '1;
      fill_r      <= '0;
      ovf_cnt_r   <= '0;
      level_r     <= srt_pkg::LEVEL_RESET;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok;
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    start_r     <= start_nxt;
    step_r      <= step_nxt;
    here_r      <= here_nxt;
    falling_r   <= falling_nxt;
    res_pos_r   <= res_pos_nxt;
    res_hit_r   <= res_hit_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_total_r, out_found_r, out_idx_r};

  // a search transaction drops ready for at least the next cycle
  a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == srt_pkg::SRT_OP_SEARCH) |=> !in_tready)
    else $error("ready stayed high after a search transaction");

  // the walk never goes past half the ring
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::SRT_SCAN) |-> (step_r <= LAST_STEP))
    else $error("search step counter beyond half the ring");

  // fill count saturates at the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_COUNT)
    else $error("fill count beyond ring depth");

  // a new result only comes out of the result state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == srt_pkg::SRT_RESULT))
    else $error("result register loaded outside the result state");

endmodule
